FILE: rtl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg: shared types and constants of the compress stream decoder
// Holds the header phases, the sequencer states, the request modes, the
// status codes and the fixed LZW constants.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    // Request modes carried on the slave-side tuser.
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_PULL = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    // Sticky status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_BAD_BITS = 2'd2;
    localparam logic [1:0] ST_BAD_CODE = 2'd3;

    // Header and code constants.
    localparam logic [7:0] MAGIC_FIRST  = 8'h1f;
    localparam logic [7:0] MAGIC_SECOND = 8'h9d;
    localparam logic [4:0] INIT_CODE_BITS = 5'd9;
    localparam logic [4:0] MIN_MAX_BITS   = 5'd12;
    localparam int         CLEAR_CODE     = 256;
    localparam int         FIRST_FREE     = 257;
    localparam int         GROUP_BYTES    = 16;

    // Stream phase, one-hot.
    typedef enum logic [5:0] {
        PH_MAGIC1 = 6'b000001,
        PH_MAGIC2 = 6'b000010,
        PH_FLAGS  = 6'b000100,
        PH_BODY   = 6'b001000,
        PH_ENDED  = 6'b010000,
        PH_ERROR  = 6'b100000
    } phase_t;

    // Decode sequencer, one-hot.
    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_FETCH    = 9'b000000010,
        S_CHECK    = 9'b000000100,
        S_BITS     = 9'b000001000,
        S_CODE     = 9'b000010000,
        S_CHAIN    = 9'b000100000,
        S_CHAIN_RD = 9'b001000000,
        S_POP      = 9'b010000000,
        S_POP_RD   = 9'b100000000
    } seq_t;

endpackage

FILE: rtl/lzwd_dict.sv
// ----------------------------------------------------------------------------
// lzwd_dict: string table of the decoder
// Prefix and suffix memories, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lzwd_dict #(
    parameter int AW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] wprefix,
    input  logic [7:0]    wsuffix,
    input  logic [AW-1:0] raddr,
    output logic [AW-1:0] rprefix,
    output logic [7:0]    rsuffix
);
    import lzwd_pkg::*;

    logic [AW-1:0] prefix_mem [2**AW];
    logic [7:0]    suffix_mem [2**AW];

    // Table update when a new string is added.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            prefix_mem[waddr] <= wprefix;
            suffix_mem[waddr] <= wsuffix;
        end
    end

    // Registered read for chain unwinding.
    always_ff @(posedge clk)
    begin
        rprefix <= prefix_mem[raddr];
        rsuffix <= suffix_mem[raddr];
    end

endmodule

FILE: rtl/lzwd_stack.sv
// ----------------------------------------------------------------------------
// lzwd_stack: output stack memory
// Holds decoded bytes of one string in reverse order until they are pulled.
// ----------------------------------------------------------------------------
module lzwd_stack #(
    parameter int AW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    import lzwd_pkg::*;

    logic [7:0] stack_mem [2**AW];

    // Push port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            stack_mem[waddr] <= wdata;
        end
    end

    // Registered pop read.
    always_ff @(posedge clk)
    begin
        rdata <= stack_mem[raddr];
    end

endmodule

FILE: rtl/lzw_compress_stream_decoder.sv
// ----------------------------------------------------------------------------
// lzw_compress_stream_decoder: Unix compress (.Z) stream decoder
// Checks the header, unpacks LSB-first codes from byte groups and expands
// them through the string table and the output stack, one byte per pull.
// ----------------------------------------------------------------------------
// Push, end and idle requests are answered from the idle state; a pull served
// from the stack passes through the pop and pop-read states. A pull that
// decodes a code passes through fetch, group check, bit unpacking (one bit per
// cycle from the group register) and the code check, then the prefix chain (one
// table read per table entry), then the pop; a CLEAR code adds another fetch.
// One request is worked at a time.
// Reset (rst_n low, asynchronous) returns to waiting for the first magic byte.
module lzw_compress_stream_decoder #(
    parameter int MAX_CODE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [4:0] m_tuser    // [0] out_valid, [1] need_input, [2] done_res, [4:3] status
);
    import lzwd_pkg::*;

    localparam int AW = MAX_CODE_BITS;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH = CW'(1) << AW;
    localparam logic [CW-1:0] CLEAR_C = CW'(CLEAR_CODE);
    localparam logic [CW-1:0] FREE_C = CW'(FIRST_FREE);

    phase_t phase_reg, phase_next;
    seq_t state_reg, state_next;
    logic [1:0] err_reg, err_next;
    logic [8*GROUP_BYTES-1:0] gbuf_reg, gbuf_next;
    logic [4:0] seen_reg, seen_next;
    logic [7:0] boff_reg, boff_next;
    logic [4:0] cw_reg, cw_next;
    logic [4:0] mw_reg, mw_next;
    logic bmode_reg, bmode_next;
    logic [CW-1:0] nfc_reg, nfc_next;
    logic [CW-1:0] prev_reg, prev_next;
    logic pvalid_reg, pvalid_next;
    logic [7:0] fchar_reg, fchar_next;
    logic skip_reg, skip_next;
    logic [CW-1:0] code_reg, code_next;
    logic [CW-1:0] incode_reg, incode_next;
    logic [4:0] bitcnt_reg, bitcnt_next;
    logic [CW-1:0] scount_reg, scount_next;
    logic mvalid_reg, mvalid_next;
    logic [7:0] obyte_reg, obyte_next;
    logic [4:0] ouser_reg, ouser_next;

    logic accept;
    logic in_hand;
    logic [CW-1:0] limit;
    logic [8:0] need_bits;
    logic [7:0] bpos;
    logic push;
    logic [7:0] push_data;
    logic dict_we;
    logic [AW-1:0] dict_raddr;
    logic [AW-1:0] dict_rprefix;
    logic [7:0] dict_rsuffix;
    logic [AW-1:0] stack_raddr;
    logic [7:0] stack_rdata;
    logic res_load;
    logic [7:0] res_byte;
    logic res_valid, res_need, res_done;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_tvalid = mvalid_reg;
    assign m_tdata = obyte_reg;
    assign m_tuser = ouser_reg;

    // Group and width bookkeeping shared by the fetch steps.
    assign in_hand = (seen_reg >= cw_reg) || ((phase_reg == PH_ENDED) && (seen_reg != 5'd0));
    assign limit = (cw_reg == mw_reg) ? (CW'(1) << mw_reg) : ((CW'(1) << cw_reg) - CW'(1));
    assign need_bits = {1'b0, boff_reg} + {4'd0, cw_reg};
    assign bpos = boff_reg + {3'd0, bitcnt_reg};
    assign dict_raddr = code_reg[AW-1:0];
    assign stack_raddr = AW'(scount_reg - CW'(1));

    // Sequencer and stream state.
    always_comb
    begin
        phase_next = phase_reg;
        state_next = state_reg;
        err_next = err_reg;
        gbuf_next = gbuf_reg;
        seen_next = seen_reg;
        boff_next = boff_reg;
        cw_next = cw_reg;
        mw_next = mw_reg;
        bmode_next = bmode_reg;
        nfc_next = nfc_reg;
        prev_next = prev_reg;
        pvalid_next = pvalid_reg;
        fchar_next = fchar_reg;
        skip_next = skip_reg;
        code_next = code_reg;
        incode_next = incode_reg;
        bitcnt_next = bitcnt_reg;
        scount_next = scount_reg;
        push = 1'b0;
        push_data = fchar_reg;
        dict_we = 1'b0;
        res_load = 1'b0;
        res_byte = 8'd0;
        res_valid = 1'b0;
        res_need = 1'b0;
        res_done = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        MODE_PUSH:
                        begin
                            res_load = 1'b1;
                            case (phase_reg)
                                PH_MAGIC1:
                                begin
                                    if (s_tdata == MAGIC_FIRST)
                                    begin
                                        phase_next = PH_MAGIC2;
                                    end
                                    else
                                    begin
                                        phase_next = PH_ERROR;
                                        err_next = ST_BAD_MAGIC;
                                    end
                                end
                                PH_MAGIC2:
                                begin
                                    if (s_tdata == MAGIC_SECOND)
                                    begin
                                        phase_next = PH_FLAGS;
                                    end
                                    else
                                    begin
                                        phase_next = PH_ERROR;
                                        err_next = ST_BAD_MAGIC;
                                    end
                                end
                                PH_FLAGS:
                                begin
                                    if ((s_tdata[4:0] > 5'(MAX_CODE_BITS))
                                        || (s_tdata[4:0] < MIN_MAX_BITS))
                                    begin
                                        phase_next = PH_ERROR;
                                        err_next = ST_BAD_BITS;
                                    end
                                    else
                                    begin
                                        mw_next = s_tdata[4:0];
                                        bmode_next = s_tdata[7];
                                        cw_next = INIT_CODE_BITS;
                                        nfc_next = s_tdata[7] ? FREE_C : CLEAR_C;
                                        pvalid_next = 1'b0;
                                        skip_next = 1'b0;
                                        seen_next = 5'd0;
                                        boff_next = 8'd0;
                                        scount_next = '0;
                                        phase_next = PH_BODY;
                                    end
                                end
                                PH_BODY:
                                begin
                                    if ((seen_reg < cw_reg) && (seen_reg < 5'(GROUP_BYTES)))
                                    begin
                                        gbuf_next[8*seen_reg[3:0] +: 8] = s_tdata;
                                        seen_next = seen_reg + 5'd1;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        MODE_END:
                        begin
                            res_load = 1'b1;
                            if ((phase_reg == PH_MAGIC1) || (phase_reg == PH_MAGIC2)
                                || (phase_reg == PH_FLAGS))
                            begin
                                phase_next = PH_ERROR;
                                err_next = ST_BAD_MAGIC;
                            end
                            else if (phase_reg == PH_BODY)
                            begin
                                phase_next = PH_ENDED;
                            end
                        end
                        MODE_PULL:
                        begin
                            if ((phase_reg == PH_BODY) || (phase_reg == PH_ENDED))
                            begin
                                state_next = (scount_reg == '0) ? S_FETCH : S_POP;
                            end
                            else
                            begin
                                res_load = 1'b1;
                                res_need = (phase_reg != PH_ERROR);
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                // Close the group when it is used up, a clear was seen, or the width grows.
                if (in_hand && (skip_reg || (need_bits > {1'b0, seen_reg, 3'd0})
                    || (nfc_reg > limit)))
                begin
                    if ((nfc_reg > limit) && (cw_reg < mw_reg))
                    begin
                        cw_next = cw_reg + 5'd1;
                    end
                    if (skip_reg)
                    begin
                        cw_next = INIT_CODE_BITS;
                        skip_next = 1'b0;
                    end
                    seen_next = 5'd0;
                    boff_next = 8'd0;
                end
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!in_hand)
                begin
                    res_load = 1'b1;
                    res_done = (phase_reg == PH_ENDED);
                    res_need = (phase_reg != PH_ENDED);
                    state_next = S_IDLE;
                end
                else
                begin
                    code_next = '0;
                    bitcnt_next = 5'd0;
                    state_next = S_BITS;
                end
            end
            S_BITS:
            begin
                // One code bit per cycle, LSB first.
                code_next = code_reg | (CW'(gbuf_reg[bpos[6:0]]) << bitcnt_reg);
                if (bitcnt_reg == (cw_reg - 5'd1))
                begin
                    boff_next = boff_reg + {3'd0, cw_reg};
                    state_next = S_CODE;
                end
                else
                begin
                    bitcnt_next = bitcnt_reg + 5'd1;
                end
            end
            S_CODE:
            begin
                if ((code_reg == CLEAR_C) && bmode_reg)
                begin
                    skip_next = 1'b1;
                    nfc_next = FREE_C;
                    pvalid_next = 1'b0;
                    state_next = S_FETCH;
                end
                else
                begin
                    incode_next = code_reg;
                    state_next = S_CHAIN;
                    if (code_reg >= nfc_reg)
                    begin
                        if ((code_reg > nfc_reg) || !pvalid_reg)
                        begin
                            phase_next = PH_ERROR;
                            err_next = ST_BAD_CODE;
                            res_load = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            // Code not yet in the table: repeat the previous string.
                            push = 1'b1;
                            push_data = fchar_reg;
                            code_next = prev_reg;
                        end
                    end
                end
            end
            S_CHAIN:
            begin
                if (code_reg >= CLEAR_C)
                begin
                    state_next = S_CHAIN_RD;
                end
                else
                begin
                    fchar_next = code_reg[7:0];
                    push = 1'b1;
                    push_data = code_reg[7:0];
                    if (pvalid_reg && (nfc_reg < (CW'(1) << mw_reg)))
                    begin
                        dict_we = 1'b1;
                        nfc_next = nfc_reg + CW'(1);
                    end
                    prev_next = incode_reg;
                    pvalid_next = 1'b1;
                    state_next = S_POP;
                end
            end
            S_CHAIN_RD:
            begin
                push = 1'b1;
                push_data = dict_rsuffix;
                code_next = {1'b0, dict_rprefix};
                state_next = S_CHAIN;
            end
            S_POP:
            begin
                scount_next = scount_reg - CW'(1);
                state_next = S_POP_RD;
            end
            S_POP_RD:
            begin
                res_load = 1'b1;
                res_valid = 1'b1;
                res_byte = stack_rdata;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Stack push, saturating at the stack depth.
        if (push && (scount_reg < DEPTH))
        begin
            scount_next = scount_reg + CW'(1);
        end
    end

    // Result register toward the master side.
    always_comb
    begin
        mvalid_next = mvalid_reg;
        obyte_next = obyte_reg;
        ouser_next = ouser_reg;
        if (m_tvalid && m_tready)
        begin
            mvalid_next = 1'b0;
        end
        if (res_load)
        begin
            mvalid_next = 1'b1;
            obyte_next = res_byte;
            ouser_next = {err_next, res_done, res_need, res_valid};
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC1;
            state_reg <= S_IDLE;
            err_reg <= ST_OK;
            seen_reg <= 5'd0;
            boff_reg <= 8'd0;
            cw_reg <= INIT_CODE_BITS;
            mw_reg <= 5'(MAX_CODE_BITS);
            bmode_reg <= 1'b1;
            nfc_reg <= FREE_C;
            pvalid_reg <= 1'b0;
            fchar_reg <= 8'd0;
            skip_reg <= 1'b0;
            scount_reg <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            state_reg <= state_next;
            err_reg <= err_next;
            seen_reg <= seen_next;
            boff_reg <= boff_next;
            cw_reg <= cw_next;
            mw_reg <= mw_next;
            bmode_reg <= bmode_next;
            nfc_reg <= nfc_next;
            pvalid_reg <= pvalid_next;
            fchar_reg <= fchar_next;
            skip_reg <= skip_next;
            scount_reg <= scount_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        gbuf_reg <= gbuf_next;
        prev_reg <= prev_next;
        code_reg <= code_next;
        incode_reg <= incode_next;
        bitcnt_reg <= bitcnt_next;
        obyte_reg <= obyte_next;
        ouser_reg <= ouser_next;
    end

    lzwd_dict #(
        .AW (AW)
    ) u_dict (
        .clk     (clk),
        .we      (dict_we),
        .waddr   (nfc_reg[AW-1:0]),
        .wprefix (prev_reg[AW-1:0]),
        .wsuffix (code_reg[7:0]),
        .raddr   (dict_raddr),
        .rprefix (dict_rprefix),
        .rsuffix (dict_rsuffix)
    );

    lzwd_stack #(
        .AW (AW)
    ) u_stack (
        .clk   (clk),
        .we    (push && (scount_reg < DEPTH)),
        .waddr (scount_reg[AW-1:0]),
        .wdata (push_data),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

`ifndef SYNTH
    // An error phase is never left.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERROR) |=> (phase_reg == PH_ERROR))
        else $error("error phase left");

    // The stack never holds more entries than its depth.
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scount_reg <= DEPTH)
        else $error("stack count overflow");

    // A result never carries a byte together with a need or done flag.
    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($countones(m_tuser[2:0]) <= 1))
        else $error("conflicting result flags");

    // A pop always follows a nonempty stack.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> (scount_reg != '0))
        else $error("pop from empty stack");
`endif

endmodule

FILE: tb/sv/lzwd_checker.sv
// ----------------------------------------------------------------------------
// lzwd_checker: response predictor and scoreboard for the stream decoder
// Watches both stream channels, works out the response of every accepted
// request from its own model of the decoder, and compares each response
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lzwd_checker #(
    parameter int MAX_CODE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [1:0] s_tuser,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [4:0] m_tuser,
    output int         fail_count,
    output int         pending
);
    import lzwd_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic       done;
        logic       need;
        logic       valid;
        logic [7:0] data;
    } response_t;

    // Model of the decoder state.
    logic [15:0] prefix_mem [65536];
    logic [7:0]  suffix_mem [65536];
    logic [7:0]  unwind_mem [65536];
    logic [7:0]  group_mem  [GROUP_BYTES];
    int          unwind_depth;
    int          group_fill;
    int          bit_pos;
    int          width;
    int          width_max;
    logic        block_on;
    int          free_code;
    int          last_code;
    logic        last_ok;
    logic [7:0]  lead_char;
    logic        skip_group;
    phase_t      phase;
    logic [1:0]  err_code;

    response_t   response_q [$];

    initial begin
        unwind_depth = 0;
        group_fill   = 0;
        bit_pos      = 0;
        width        = INIT_CODE_BITS;
        width_max    = 16;
        block_on     = 1'b1;
        free_code    = FIRST_FREE;
        last_code    = 0;
        last_ok      = 1'b0;
        lead_char    = 8'd0;
        skip_group   = 1'b0;
        phase        = PH_MAGIC1;
        err_code     = ST_OK;
        fail_count   = 0;
        pending      = 0;
    end

    function automatic int code_ceiling();
        if (width == width_max)
            return 1 << width_max;
        return (1 << width) - 1;
    endfunction

    function automatic logic group_ready();
        if (group_fill >= width)
            return 1'b1;
        return phase == PH_ENDED && group_fill > 0;
    endfunction

    function automatic void open_group();
        if (free_code > code_ceiling() && width < width_max)
            width++;
        if (skip_group) begin
            width      = INIT_CODE_BITS;
            skip_group = 1'b0;
        end
        group_fill = 0;
        bit_pos    = 0;
    endfunction

    // Returns 0 with a code, 1 when more input is needed, 2 when finished.
    function automatic int take_code(output int code);
        int pos;
        code = 0;
        if (group_ready()) begin
            if (skip_group || bit_pos + width > group_fill * 8
                || free_code > code_ceiling())
                open_group();
        end
        if (!group_ready())
            return (phase == PH_ENDED) ? 2 : 1;
        for (int i = 0; i < width; i++) begin
            pos = bit_pos + i;
            code |= int'(group_mem[(pos >> 3) & 15][pos & 7]) << i;
        end
        bit_pos += width;
        return 0;
    endfunction

    function automatic void stack_push(logic [7:0] b);
        if (unwind_depth < 65536) begin
            unwind_mem[unwind_depth] = b;
            unwind_depth++;
        end
    endfunction

    // Returns 0 when the stack was filled, 1 need input, 2 done, 3 error.
    function automatic int expand_code();
        int code;
        int in_code;
        int r;
        int guard;
        while (1) begin
            r = take_code(code);
            if (r != 0)
                return r;
            if (code == CLEAR_CODE && block_on) begin
                skip_group = 1'b1;
                free_code  = FIRST_FREE;
                last_ok    = 1'b0;
            end else begin
                break;
            end
        end
        in_code = code;
        if (code >= free_code) begin
            if (code > free_code || !last_ok) begin
                err_code = ST_BAD_CODE;
                phase    = PH_ERROR;
                return 3;
            end
            stack_push(lead_char);
            code = last_code;
        end
        guard = 0;
        while (code >= 256 && guard < 65536) begin
            stack_push(suffix_mem[code & 16'hffff]);
            code = prefix_mem[code & 16'hffff];
            guard++;
        end
        lead_char = code[7:0];
        stack_push(lead_char);
        if (last_ok && free_code < (1 << width_max)) begin
            prefix_mem[free_code & 16'hffff] = last_code[15:0];
            suffix_mem[free_code & 16'hffff] = lead_char;
            free_code++;
        end
        last_code = in_code;
        last_ok   = 1'b1;
        return 0;
    endfunction

    // Updates the model with one request and returns its response.
    function automatic response_t predict_response(logic [1:0] mode, logic [7:0] b);
        response_t rsp;
        int        r;
        int        mb;
        rsp = '0;
        if (mode == MODE_PUSH) begin
            case (phase)
                PH_MAGIC1: if (b == MAGIC_FIRST) phase = PH_MAGIC2;
                           else begin err_code = ST_BAD_MAGIC; phase = PH_ERROR; end
                PH_MAGIC2: if (b == MAGIC_SECOND) phase = PH_FLAGS;
                           else begin err_code = ST_BAD_MAGIC; phase = PH_ERROR; end
                PH_FLAGS: begin
                    mb = int'(b[4:0]);
                    if (mb > MAX_CODE_BITS || mb < int'(MIN_MAX_BITS)) begin
                        err_code = ST_BAD_BITS;
                        phase    = PH_ERROR;
                    end else begin
                        width_max    = mb;
                        block_on     = b[7];
                        width        = INIT_CODE_BITS;
                        free_code    = b[7] ? FIRST_FREE : CLEAR_CODE;
                        last_ok      = 1'b0;
                        skip_group   = 1'b0;
                        group_fill   = 0;
                        bit_pos      = 0;
                        unwind_depth = 0;
                        phase        = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (group_fill < width && group_fill < GROUP_BYTES) begin
                        group_mem[group_fill] = b;
                        group_fill++;
                    end
                end
                default: ;
            endcase
        end else if (mode == MODE_END) begin
            if (phase inside {PH_MAGIC1, PH_MAGIC2, PH_FLAGS}) begin
                err_code = ST_BAD_MAGIC;
                phase    = PH_ERROR;
            end else if (phase == PH_BODY) begin
                phase = PH_ENDED;
            end
        end else if (mode == MODE_PULL) begin
            if (phase inside {PH_MAGIC1, PH_MAGIC2, PH_FLAGS}) begin
                rsp.need = 1'b1;
            end else if (phase inside {PH_BODY, PH_ENDED}) begin
                r = 0;
                if (unwind_depth == 0)
                    r = expand_code();
                if (r == 0 && unwind_depth > 0) begin
                    unwind_depth--;
                    rsp.data  = unwind_mem[unwind_depth];
                    rsp.valid = 1'b1;
                end else if (r == 1) begin
                    rsp.need = 1'b1;
                end else if (r == 2) begin
                    rsp.done = 1'b1;
                end
            end
        end
        rsp.status = err_code;
        return rsp;
    endfunction

    // Compare responses first, then record the request of the same edge.
    always @(posedge clk) begin
        response_t want;
        response_t got;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser[4:3], m_tuser[2], m_tuser[1], m_tuser[0], m_tdata};
                if (response_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("lzwd_checker: response with none expected: data %h flags %b",
                                 m_tdata, m_tuser);
                end else begin
                    want = response_q.pop_front();
                    if (got.data !== want.data || got.valid !== want.valid
                        || got.need !== want.need || got.done !== want.done
                        || got.status !== want.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"lzwd_checker: mismatch: expected byte %h valid %b ",
                                      "need %b done %b status %0d, got byte %h valid %b ",
                                      "need %b done %b status %0d"},
                                     want.data, want.valid, want.need, want.done,
                                     want.status, got.data, got.valid, got.need,
                                     got.done, got.status);
                    end
                end
            end
            if (s_tvalid && s_tready)
                response_q.push_back(predict_response(s_tuser, s_tdata));
            pending = response_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the compress stream decoder
// Builds one well-formed compressed stream from random codes (literals,
// dictionary references, the KwKwK case, CLEAR codes and width growth),
// feeds it group by group as pulls ask for input, then ends the stream,
// optionally with an invalid code, and drains it. A separate checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
    import lzwd_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int         CODE_COUNT = 300;
    localparam int         STALL_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [4:0] m_tuser;
    int         fail_count;
    int         pending;

    int         sent_count = 0;
    int         reply_count = 0;
    logic       saw_need = 1'b0;
    logic       saw_done = 1'b0;
    logic       saw_error = 1'b0;
    logic       idle_on = 1'b0;
    int         stall_left = 0;
    int         quiet_cycles = 0;

    // Compressed body, split into groups.
    logic [7:0] body_bytes [$];
    int         group_len [$];

    lzw_compress_stream_decoder #(.MAX_CODE_BITS(16)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    lzwd_checker #(.MAX_CODE_BITS(16)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver stalls in random bursts.
    assign m_tready = (stall_left == 0);
    always @(negedge clk) begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (idle_on && $urandom_range(0, 6) == 0)
            stall_left <= $urandom_range(1, 11);
    end

    // Track what the responses reported.
    always @(posedge clk) begin
        if (m_tvalid && m_tready) begin
            reply_count++;
            if (m_tuser[1]) saw_need = 1'b1;
            if (m_tuser[2]) saw_done = 1'b1;
            if (m_tuser[4:3] != ST_OK) saw_error = 1'b1;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Send one request; called and returning at a falling edge.
    task automatic send_request(input logic [1:0] mode, input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        sent_count++;
        @(negedge clk);
    endtask

    // Hold off until every request has its response.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (reply_count != sent_count) @(negedge clk);
    endtask

    function automatic int ceiling_of(int w, int wmax);
        if (w == wmax)
            return 1 << wmax;
        return (1 << w) - 1;
    endfunction

    // Build a valid code stream mirroring the decoder's grouping rules.
    function automatic void build_body(int wmax, logic blk, logic add_bad);
        logic [7:0] cur [GROUP_BYTES];
        int w;
        int nf;
        int bp;
        int c;
        int r;
        int pos;
        int lowest;
        logic pv;
        logic sk;
        w = INIT_CODE_BITS;
        nf = blk ? FIRST_FREE : CLEAR_CODE;
        lowest = nf;
        bp = 0;
        pv = 1'b0;
        sk = 1'b0;
        foreach (cur[i]) cur[i] = 8'd0;
        for (int k = 0; k <= CODE_COUNT; k++) begin
            if (sk || bp + w > 8 * w || nf > ceiling_of(w, wmax)) begin
                for (int i = 0; i < w; i++) begin
                    body_bytes.push_back(cur[i]);
                    cur[i] = 8'd0;
                end
                group_len.push_back(w);
                if (nf > ceiling_of(w, wmax) && w < wmax) w++;
                if (sk) begin
                    w = INIT_CODE_BITS;
                    sk = 1'b0;
                end
                bp = 0;
            end
            if (k == CODE_COUNT) begin
                // Optional invalid code, one past the next free entry.
                if (!add_bad || nf + 1 >= (1 << w)) break;
                c = nf + 1;
            end else begin
                r = $urandom_range(0, 99);
                if (blk && pv && r < 3)
                    c = CLEAR_CODE;
                else if (!pv || r < 55)
                    c = $urandom_range(0, 255);
                else if (r < 62 && nf < (1 << wmax))
                    c = nf;
                else if (nf > lowest)
                    c = $urandom_range(lowest, nf - 1);
                else
                    c = $urandom_range(0, 255);
            end
            for (int i = 0; i < w; i++) begin
                pos = bp + i;
                cur[pos >> 3][pos & 7] = c[i];
            end
            bp += w;
            if (k == CODE_COUNT) break;
            if (c == CLEAR_CODE && blk) begin
                sk = 1'b1;
                nf = FIRST_FREE;
                pv = 1'b0;
            end else begin
                if (pv && nf < (1 << wmax)) nf++;
                pv = 1'b1;
            end
        end
        // Short last group holding only the bytes that its codes reach.
        if (bp > 0) begin
            for (int i = 0; i < (bp + 7) / 8; i++)
                body_bytes.push_back(cur[i]);
            group_len.push_back((bp + 7) / 8);
        end
    endfunction

    initial begin
        int   wmax;
        logic blk;
        int   gi;
        int   rd;
        int   burst;
        logic [7:0] flags;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tuser  = MODE_PUSH;

        wmax  = $urandom_range(12, 16);
        blk   = ($urandom_range(0, 3) != 0);
        flags = {blk, 2'($urandom_range(0, 3)), 5'(wmax)};
        build_body(wmax, blk, 1'($urandom_range(0, 1)));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Header, with a pull and an unknown mode before it is complete.
        send_request(MODE_PULL, 8'($urandom));
        send_request(MODE_NONE, 8'($urandom));
        send_request(MODE_PUSH, MAGIC_FIRST);
        send_request(MODE_PULL, 8'd0);
        send_request(MODE_PUSH, MAGIC_SECOND);
        send_request(MODE_PUSH, flags);

        // Body: pull in bursts; feed the next group once input is asked for.
        gi = 0;
        rd = 0;
        while (!saw_error) begin
            saw_need = 1'b0;
            burst = $urandom_range(1, 4);
            repeat (burst) send_request(MODE_PULL, 8'($urandom));
            if ($urandom_range(0, 19) == 0)
                send_request(MODE_NONE, 8'($urandom));
            wait_drained();
            if (saw_need) begin
                if (gi == group_len.size()) break;
                idle_on = ($urandom_range(0, 3) != 0);
                for (int i = 0; i < group_len[gi]; i++)
                    send_request(MODE_PUSH, body_bytes[rd + i]);
                rd += group_len[gi];
                // A surplus byte on a full group is dropped.
                if (gi + 1 < group_len.size() && $urandom_range(0, 9) == 0)
                    send_request(MODE_PUSH, 8'($urandom));
                gi++;
            end
        end

        // End of input, then drain without idling.
        idle_on = 1'b0;
        send_request(MODE_END, 8'd0);
        send_request(MODE_PUSH, 8'($urandom));
        saw_done = 1'b0;
        while (!saw_done && !saw_error) begin
            send_request(MODE_PULL, 8'd0);
            wait_drained();
        end
        send_request(MODE_PULL, 8'd0);
        send_request(MODE_END, 8'd0);
        send_request(MODE_PULL, 8'd0);
        wait_drained();

        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
